// ===== rtl/terminal_fifo_bridge_assert.svh =====
// assertion macros for the terminal fifo bridge
`ifndef TERMINAL_FIFO_BRIDGE_ASSERT_SVH
`define TERMINAL_FIFO_BRIDGE_ASSERT_SVH

`ifndef NO_ASSERTIONS
// same-cycle implication, sampled on clk, off during reset
`define TFB_ASSERT_NOW(label, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
        else $error("terminal fifo bridge check failed");
// next-cycle implication, sampled on clk, off during reset
`define TFB_ASSERT_NEXT(label, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error("terminal fifo bridge check failed");
`else
`define TFB_ASSERT_NOW(label, cond, expr)
`define TFB_ASSERT_NEXT(label, cond, expr)
`endif

`endif

// ===== rtl/tfb_pkg.sv =====
// shared types, constants and codes of the terminal fifo bridge
`default_nettype none

package tfb_pkg;

    localparam int RX_DEPTH = 128;
    localparam int TX_DEPTH = 512;
    localparam int RX_AW = $clog2(RX_DEPTH);
    localparam int RX_LW = $clog2(RX_DEPTH + 1);
    localparam int TX_AW = $clog2(TX_DEPTH);
    localparam int TX_LW = $clog2(TX_DEPTH + 1);

    typedef logic [7:0]  byte_t;
    typedef logic [2:0]  kind_t;
    typedef logic [15:0] drop_t;
    typedef logic [31:0] count_t;

    localparam kind_t KIND_CPU_READ   = 3'd0;
    localparam kind_t KIND_CPU_WRITE  = 3'd1;
    localparam kind_t KIND_NET_BYTE   = 3'd2;
    localparam kind_t KIND_NET_PULL   = 3'd3;
    localparam kind_t KIND_CONNECT    = 3'd4;
    localparam kind_t KIND_DISCONNECT = 3'd5;
    localparam kind_t KIND_ADD_DROPS  = 3'd6;

    localparam byte_t PORT_DATA   = 8'h00;
    localparam byte_t PORT_STATUS = 8'h01;
    localparam byte_t BYTE_ZERO   = 8'h00;
    localparam byte_t BYTE_UNMAP  = 8'hFF;
    localparam byte_t BYTE_LF     = 8'h0A;
    localparam byte_t BYTE_CR     = 8'h0D;

    localparam int ST_RX_READY = 0;
    localparam int ST_TX_ROOM  = 1;
    localparam int ST_CLIENT   = 7;

    typedef enum logic [1:0] {
        SEL_NONE = 2'd0,
        SEL_RX   = 2'd1,
        SEL_TX   = 2'd2
    } sel_t;

    typedef struct packed {
        kind_t kind;
        byte_t port;
        byte_t write_byte;
        byte_t net_byte;
        drop_t drop_add;
    } item_t;

    typedef struct packed {
        sel_t   sel;
        byte_t  imm_data;
        logic   pull_valid;
        count_t rx_total;
        count_t tx_total;
        logic   connected;
    } pend_t;

    typedef struct packed {
        logic             we;
        logic [RX_AW-1:0] waddr;
        byte_t            wdata;
        logic             re;
        logic [RX_AW-1:0] raddr;
    } rx_cmd_t;

    typedef struct packed {
        logic             we;
        logic [TX_AW-1:0] waddr;
        byte_t            wdata;
        logic             re;
        logic [TX_AW-1:0] raddr;
    } tx_cmd_t;

    typedef struct packed {
        logic [RX_LW-1:0] rx_level;
        logic [TX_LW-1:0] tx_level;
    } lvl_t;

endpackage

`default_nettype wire

// ===== rtl/tfb_in_if.sv =====
// input item channel of the terminal fifo bridge
`default_nettype none

interface tfb_in_if;
    logic                valid;
    logic                ready;
    tfb_pkg::kind_t      kind;
    tfb_pkg::byte_t      port;
    tfb_pkg::byte_t      write_byte;
    tfb_pkg::byte_t      net_byte;
    tfb_pkg::drop_t      drop_add;

    modport source (output valid, kind, port, write_byte, net_byte, drop_add, input ready);
    modport sink   (input valid, kind, port, write_byte, net_byte, drop_add, output ready);
endinterface

`default_nettype wire

// ===== rtl/tfb_out_if.sv =====
// result item channel of the terminal fifo bridge
`default_nettype none

interface tfb_out_if;
    logic                valid;
    logic                ready;
    tfb_pkg::byte_t      read_data;
    tfb_pkg::byte_t      pull_byte;
    logic                pull_valid;
    tfb_pkg::count_t     rx_drop_total;
    tfb_pkg::count_t     tx_drop_total;
    logic                connected;

    modport source (output valid, read_data, pull_byte, pull_valid, rx_drop_total,
                    tx_drop_total, connected, input ready);
    modport sink   (input valid, read_data, pull_byte, pull_valid, rx_drop_total,
                    tx_drop_total, connected, output ready);
endinterface

`default_nettype wire

// ===== rtl/tfb_ram.sv =====
// generic single-write, single-read ram with registered read data
`default_nettype none

module tfb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/tfb_ctrl.sv =====
// ring pointers, fill levels, drop counters and ram commands
`default_nettype none

module tfb_ctrl (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             accept,
    input  wire tfb_pkg::item_t   item,
    output tfb_pkg::rx_cmd_t      rx_cmd,
    output tfb_pkg::tx_cmd_t      tx_cmd,
    output tfb_pkg::pend_t        pend,
    output tfb_pkg::lvl_t         lvl
);
    import tfb_pkg::*;

    logic [RX_AW-1:0] rx_head_reg, rx_head_next;
    logic [RX_LW-1:0] rx_level_reg, rx_level_next;
    logic [TX_AW-1:0] tx_head_reg, tx_head_next;
    logic [TX_LW-1:0] tx_level_reg, tx_level_next;
    count_t           rx_cnt_reg, rx_cnt_next;
    count_t           tx_cnt_reg, tx_cnt_next;
    logic             flag_reg, flag_next;

    logic [RX_AW-1:0] rx_head_inc, rx_tail;
    logic [TX_AW-1:0] tx_head_inc, tx_tail;
    logic [RX_LW:0]   rx_sum;
    logic [TX_LW:0]   tx_sum;
    logic             rx_full, rx_empty, tx_full, tx_empty;
    byte_t            net_mapped;

    // wrap helpers, sums stay below twice the depth
    assign rx_head_inc = (rx_head_reg == RX_AW'(RX_DEPTH - 1)) ? '0 : rx_head_reg + 1'b1;
    assign tx_head_inc = (tx_head_reg == TX_AW'(TX_DEPTH - 1)) ? '0 : tx_head_reg + 1'b1;
    assign rx_sum  = (RX_LW+1)'(rx_head_reg) + (RX_LW+1)'(rx_level_reg);
    assign tx_sum  = (TX_LW+1)'(tx_head_reg) + (TX_LW+1)'(tx_level_reg);
    assign rx_tail = (rx_sum >= (RX_LW+1)'(RX_DEPTH)) ?
                     RX_AW'(rx_sum - (RX_LW+1)'(RX_DEPTH)) : RX_AW'(rx_sum);
    assign tx_tail = (tx_sum >= (TX_LW+1)'(TX_DEPTH)) ?
                     TX_AW'(tx_sum - (TX_LW+1)'(TX_DEPTH)) : TX_AW'(tx_sum);
    assign rx_full  = (rx_level_reg == RX_LW'(RX_DEPTH));
    assign tx_full  = (tx_level_reg == TX_LW'(TX_DEPTH));
    assign rx_empty = (rx_level_reg == '0);
    assign tx_empty = (tx_level_reg == '0);
    assign net_mapped = (item.net_byte == BYTE_LF) ? BYTE_CR : item.net_byte;

    always_comb
    begin
        rx_head_next  = rx_head_reg;
        rx_level_next = rx_level_reg;
        tx_head_next  = tx_head_reg;
        tx_level_next = tx_level_reg;
        rx_cnt_next   = rx_cnt_reg;
        tx_cnt_next   = tx_cnt_reg;
        flag_next     = flag_reg;

        rx_cmd.we    = 1'b0;
        rx_cmd.waddr = rx_tail;
        rx_cmd.wdata = net_mapped;
        rx_cmd.re    = 1'b0;
        rx_cmd.raddr = rx_head_reg;
        tx_cmd.we    = 1'b0;
        tx_cmd.waddr = tx_tail;
        tx_cmd.wdata = item.write_byte;
        tx_cmd.re    = 1'b0;
        tx_cmd.raddr = tx_head_reg;

        pend.sel        = SEL_NONE;
        pend.imm_data   = BYTE_ZERO;
        pend.pull_valid = 1'b0;

        if (accept)
        begin
            unique case (item.kind)
                KIND_CPU_READ:
                begin
                    if (item.port == PORT_DATA)
                    begin
                        if (!rx_empty)
                        begin
                            rx_cmd.re     = 1'b1;
                            rx_head_next  = rx_head_inc;
                            rx_level_next = rx_level_reg - 1'b1;
                            pend.sel      = SEL_RX;
                        end
                    end
                    else if (item.port == PORT_STATUS)
                    begin
                        pend.imm_data[ST_RX_READY] = !rx_empty;
                        pend.imm_data[ST_TX_ROOM]  = !tx_full;
                        pend.imm_data[ST_CLIENT]   = flag_reg;
                    end
                    else
                    begin
                        pend.imm_data = BYTE_UNMAP;
                    end
                end
                KIND_CPU_WRITE:
                begin
                    if (item.port == PORT_DATA)
                    begin
                        if (!tx_full)
                        begin
                            tx_cmd.we     = 1'b1;
                            tx_level_next = tx_level_reg + 1'b1;
                        end
                        else
                        begin
                            tx_cnt_next = tx_cnt_reg + 32'd1;
                        end
                    end
                end
                KIND_NET_BYTE:
                begin
                    // when full the tail sits on the head: overwrite the oldest byte
                    rx_cmd.we = 1'b1;
                    if (rx_full)
                    begin
                        rx_head_next = rx_head_inc;
                        rx_cnt_next  = rx_cnt_reg + 32'd1;
                    end
                    else
                    begin
                        rx_level_next = rx_level_reg + 1'b1;
                    end
                end
                KIND_NET_PULL:
                begin
                    if (!tx_empty)
                    begin
                        tx_cmd.re       = 1'b1;
                        tx_head_next    = tx_head_inc;
                        tx_level_next   = tx_level_reg - 1'b1;
                        pend.sel        = SEL_TX;
                        pend.pull_valid = 1'b1;
                    end
                end
                KIND_CONNECT:
                begin
                    flag_next = 1'b1;
                end
                KIND_DISCONNECT:
                begin
                    flag_next     = 1'b0;
                    rx_head_next  = '0;
                    rx_level_next = '0;
                    tx_head_next  = '0;
                    tx_level_next = '0;
                end
                KIND_ADD_DROPS:
                begin
                    tx_cnt_next = tx_cnt_reg + 32'(item.drop_add);
                end
                default:
                begin
                    flag_next = flag_reg;
                end
            endcase
        end

        pend.rx_total  = rx_cnt_next;
        pend.tx_total  = tx_cnt_next;
        pend.connected = flag_next;
    end

    assign lvl.rx_level = rx_level_reg;
    assign lvl.tx_level = tx_level_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rx_head_reg  <= '0;
            rx_level_reg <= '0;
            tx_head_reg  <= '0;
            tx_level_reg <= '0;
            rx_cnt_reg   <= '0;
            tx_cnt_reg   <= '0;
            flag_reg     <= 1'b0;
        end
        else
        begin
            rx_head_reg  <= rx_head_next;
            rx_level_reg <= rx_level_next;
            tx_head_reg  <= tx_head_next;
            tx_level_reg <= tx_level_next;
            rx_cnt_reg   <= rx_cnt_next;
            tx_cnt_reg   <= tx_cnt_next;
            flag_reg     <= flag_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/terminal_fifo_bridge.sv =====
// top level of the terminal fifo bridge: fifo control, byte rams, result stages
//
// usage
//   in_ch carries one item per cpu access or network event (kind, port, bytes,
//   drop count); out_ch returns exactly one result item for every input item,
//   in order, with the read byte, pulled byte and the counters after the item.
//   the receive fifo (128 bytes) and transmit fifo (512 bytes) live in two
//   synchronous rams with a registered read port.
// pipeline and throughput
//   an item is accepted, its ram access issued and pointers updated on the same
//   edge; the ram read data is there in the next cycle and the result register
//   loads from it and from the pend stage once the pend stage can move forward.
//   one item per cycle is sustained while out_ch.ready stays high: the pend stage
//   and the output register form a two-deep pipe and a new item enters each
//   cycle the pend stage can move forward.
// reset
//   rst_n clears pointers, levels, drop counters, client flag and both stage
//   valid bits; ram contents are left as they are, never-pushed bytes are
//   never read. no clearing pass is needed, an item is taken right after reset.
// stall
//   while out_ch.ready is low a held result blocks the pend stage; once that is
//   full too, in_ch.ready drops until the receiver takes the result.
`default_nettype none
`include "terminal_fifo_bridge_assert.svh"

module terminal_fifo_bridge (
    input  wire logic  clk,
    input  wire logic  rst_n,
    tfb_in_if.sink     in_ch,
    tfb_out_if.source  out_ch
);
    import tfb_pkg::*;

    item_t   item;
    logic    accept;
    logic    pend_adv;
    rx_cmd_t rx_cmd;
    tx_cmd_t tx_cmd;
    pend_t   pend_in;
    lvl_t    lvl;
    byte_t   rx_rdata;
    byte_t   tx_rdata;

    // pipeline control
    logic    pend_valid_reg, pend_valid_next;
    logic    out_valid_reg, out_valid_next;
    pend_t   pend_reg;

    // result payload
    byte_t   read_data_reg;
    byte_t   pull_byte_reg;
    logic    pull_valid_reg;
    count_t  rx_total_reg;
    count_t  tx_total_reg;
    logic    connected_reg;

    assign item.kind       = in_ch.kind;
    assign item.port       = in_ch.port;
    assign item.write_byte = in_ch.write_byte;
    assign item.net_byte   = in_ch.net_byte;
    assign item.drop_add   = in_ch.drop_add;

    // the pend stage moves when the output register is free or being emptied
    assign pend_adv    = !out_valid_reg || out_ch.ready;
    assign in_ch.ready = !pend_valid_reg || pend_adv;
    assign accept      = in_ch.valid && in_ch.ready;

    tfb_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .item   (item),
        .rx_cmd (rx_cmd),
        .tx_cmd (tx_cmd),
        .pend   (pend_in),
        .lvl    (lvl)
    );

    // ram read data holds until the next read, which waits for the pend stage to move
    tfb_ram #(.WIDTH(8), .DEPTH(RX_DEPTH)) u_rx_ram (
        .clk   (clk),
        .we    (rx_cmd.we),
        .waddr (rx_cmd.waddr),
        .wdata (rx_cmd.wdata),
        .re    (rx_cmd.re),
        .raddr (rx_cmd.raddr),
        .rdata (rx_rdata)
    );

    tfb_ram #(.WIDTH(8), .DEPTH(TX_DEPTH)) u_tx_ram (
        .clk   (clk),
        .we    (tx_cmd.we),
        .waddr (tx_cmd.waddr),
        .wdata (tx_cmd.wdata),
        .re    (tx_cmd.re),
        .raddr (tx_cmd.raddr),
        .rdata (tx_rdata)
    );

    always_comb
    begin
        priority if (accept)
        begin
            pend_valid_next = 1'b1;
        end
        else if (pend_adv)
        begin
            pend_valid_next = 1'b0;
        end
        else
        begin
            pend_valid_next = pend_valid_reg;
        end

        priority if (pend_valid_reg && pend_adv)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ch.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // payload stages, no reset needed
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            pend_reg <= pend_in;
        end
        if (pend_valid_reg && pend_adv)
        begin
            unique case (pend_reg.sel)
                SEL_RX:
                begin
                    read_data_reg <= rx_rdata;
                    pull_byte_reg <= BYTE_ZERO;
                end
                SEL_TX:
                begin
                    read_data_reg <= pend_reg.imm_data;
                    pull_byte_reg <= tx_rdata;
                end
                default:
                begin
                    read_data_reg <= pend_reg.imm_data;
                    pull_byte_reg <= BYTE_ZERO;
                end
            endcase
            pull_valid_reg <= pend_reg.pull_valid;
            rx_total_reg   <= pend_reg.rx_total;
            tx_total_reg   <= pend_reg.tx_total;
            connected_reg  <= pend_reg.connected;
        end
    end

    assign out_ch.valid         = out_valid_reg;
    assign out_ch.read_data     = read_data_reg;
    assign out_ch.pull_byte     = pull_byte_reg;
    assign out_ch.pull_valid    = pull_valid_reg;
    assign out_ch.rx_drop_total = rx_total_reg;
    assign out_ch.tx_drop_total = tx_total_reg;
    assign out_ch.connected     = connected_reg;

    // an accepted item always occupies the pend stage next cycle
    `TFB_ASSERT_NEXT(a_accept_fills_pend, accept, pend_valid_reg)
    // both stages full and the receiver stalled: no new item may enter
    `TFB_ASSERT_NOW(a_full_pipe_blocks, pend_valid_reg && out_valid_reg && !out_ch.ready, !in_ch.ready)
    // fill levels never pass the fifo depths
    `TFB_ASSERT_NOW(a_level_bound, 1'b1, (lvl.rx_level <= RX_LW'(RX_DEPTH)) && (lvl.tx_level <= TX_LW'(TX_DEPTH)))

endmodule

`default_nettype wire
